FILE: hdl/scol_pkg.sv
// Shared constants, codes and stage payload types for the shape collision tester.
package scol_pkg;

  // Coordinate width; centers are signed, extents unsigned, same fixed point.
  localparam int COORD_BITS = 24;

  localparam int DIFF_W = COORD_BITS + 1;      // center difference, signed
  localparam int SPAN_W = COORD_BITS + 2;      // sum of two doubled half-spans
  localparam int RS_W   = COORD_BITS + 1;      // radius sum
  localparam int SQ_W   = 2 * COORD_BITS;      // one squared axis distance
  localparam int DIST_W = 2 * COORD_BITS + 2;  // sum of three squares
  localparam int RSQ_W  = 2 * RS_W;            // squared radius sum
  localparam int CMP_W  = DIFF_W + 2;          // signed compare of 2*d against span sum

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } op_t;

  typedef enum logic {
    KIND_SPHERE = 1'b0,
    KIND_BOX    = 1'b1
  } kind_t;

  typedef struct packed {
    logic                        sphere;
    logic [RS_W-1:0]             rs;
    logic [2:0][DIFF_W-1:0]      diff;
    logic [2:0][SPAN_W-1:0]      span_sum;
  } front_t;

  typedef struct packed {
    logic                        sphere;
    logic                        box_ok;
    logic [2:0][SQ_W-1:0]        sq;
    logic [RSQ_W-1:0]            rsq;
  } mult_t;

  typedef struct packed {
    logic                        sphere;
    logic                        box_ok;
    logic [DIST_W-1:0]           dist_sq;
    logic [RSQ_W-1:0]            rsq;
  } sum_t;

endpackage

FILE: hdl/shape_collision_test.sv
// Top level of the sphere and axis-aligned box collision tester.
// A request with op = load stores the reference shape (kind, center, extents)
// and yields no result; a request with op = test checks its shape against the
// reference stored at the moment it is accepted and yields one hit bit.
// Requests are taken one per cycle while in_stall is low, loads and tests mixed
// freely; a test right after a load sees the new reference. Sphere pairs compare
// squared center distance with the squared radius sum (strictly less); any pair
// with a box tests strict overlap on every axis, a sphere counting as its
// bounding cube. All bounds are worked at doubled scale, so results are exact
// and do not depend on the fraction bits. The pipeline is four register stages:
// differences and span sums, the 25x25 squaring multipliers, the three-way
// distance sum, and the output register. Each stage fills a bubble ahead of it,
// so out_stall only backs up as far as the stages are full.
module shape_collision_test (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  op,
  input  logic                                  kind,
  input  logic signed [scol_pkg::COORD_BITS-1:0] center_x,
  input  logic signed [scol_pkg::COORD_BITS-1:0] center_y,
  input  logic signed [scol_pkg::COORD_BITS-1:0] center_z,
  input  logic        [scol_pkg::COORD_BITS-1:0] extent_x,
  input  logic        [scol_pkg::COORD_BITS-1:0] extent_y,
  input  logic        [scol_pkg::COORD_BITS-1:0] extent_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  hit
);
  import scol_pkg::*;

  logic   front_ready;
  logic   front_valid;
  front_t front_data;
  logic   mult_ready;
  logic   mult_valid;
  mult_t  mult_data;
  logic   decide_ready;

  // Loads and tests share the first stage's ready.
  assign in_stall = !front_ready;

  scol_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .op         (op),
    .kind       (kind),
    .center_x   (center_x),
    .center_y   (center_y),
    .center_z   (center_z),
    .extent_x   (extent_x),
    .extent_y   (extent_y),
    .extent_z   (extent_z),
    .down_ready (mult_ready),
    .ready      (front_ready),
    .valid      (front_valid),
    .data       (front_data)
  );

  scol_mult u_mult (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (front_valid),
    .up         (front_data),
    .down_ready (decide_ready),
    .ready      (mult_ready),
    .valid      (mult_valid),
    .data       (mult_data)
  );

  scol_decide u_decide (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (mult_valid),
    .up        (mult_data),
    .out_stall (out_stall),
    .ready     (decide_ready),
    .out_valid (out_valid),
    .hit       (hit)
  );

endmodule

FILE: hdl/scol_front.sv
// Reference shape store and first stage: center differences, span sums, radius sum.
module scol_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic                                  op,
  input  logic                                  kind,
  input  logic signed [scol_pkg::COORD_BITS-1:0] center_x,
  input  logic signed [scol_pkg::COORD_BITS-1:0] center_y,
  input  logic signed [scol_pkg::COORD_BITS-1:0] center_z,
  input  logic        [scol_pkg::COORD_BITS-1:0] extent_x,
  input  logic        [scol_pkg::COORD_BITS-1:0] extent_y,
  input  logic        [scol_pkg::COORD_BITS-1:0] extent_z,
  input  logic                                  down_ready,
  output logic                                  ready,
  output logic                                  valid,
  output scol_pkg::front_t                      data
);
  import scol_pkg::*;

  logic                         ref_kind;
  logic signed [COORD_BITS-1:0] ref_center [3];
  logic        [COORD_BITS-1:0] ref_extent [3];
  logic signed [COORD_BITS-1:0] cen [3];
  logic        [COORD_BITS-1:0] ext [3];
  front_t                       data_next;
  logic                         take;
  logic                         load;

  assign cen[0] = center_x;
  assign cen[1] = center_y;
  assign cen[2] = center_z;
  assign ext[0] = extent_x;
  assign ext[1] = extent_y;
  assign ext[2] = extent_z;

  assign ready = !valid || down_ready;
  assign take  = in_valid && ready;
  assign load  = take && (op == OP_LOAD);

  always_comb begin
    logic [COORD_BITS:0] sa;
    logic [COORD_BITS:0] sb;
    data_next.sphere = (kind == KIND_SPHERE) && (ref_kind == KIND_SPHERE);
    data_next.rs     = RS_W'(ext[0]) + RS_W'(ref_extent[0]);
    for (int ax = 0; ax < 3; ax++) begin
      // doubled half-span: 2r for a sphere, full extent for a box
      sa = (kind == KIND_SPHERE) ? {ext[0], 1'b0} : {1'b0, ext[ax]};
      sb = (ref_kind == KIND_SPHERE) ? {ref_extent[0], 1'b0} : {1'b0, ref_extent[ax]};
      data_next.span_sum[ax] = SPAN_W'(sa) + SPAN_W'(sb);
      data_next.diff[ax]     = DIFF_W'(cen[ax]) - DIFF_W'(ref_center[ax]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      ref_kind <= KIND_SPHERE;
      for (int i = 0; i < 3; i++) begin
        ref_center[i] <= '0;
        ref_extent[i] <= '0;
      end
    end else begin
      if (ready) begin
        valid <= in_valid && (op == OP_TEST);
      end
      if (load) begin
        ref_kind <= kind;
        for (int i = 0; i < 3; i++) begin
          ref_center[i] <= cen[i];
          ref_extent[i] <= ext[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      data <= data_next;
    end
  end

  // A load stores its kind and never starts a result.
  a_load_kind: assert property (@(posedge clk) disable iff (rst)
    load |=> ref_kind == $past(kind))
    else $error("reference kind not stored on load");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    load |=> !valid)
    else $error("load request started a result");

endmodule

FILE: hdl/scol_mult.sv
// Second stage: squared axis distances, squared radius sum, per-axis box overlap.
module scol_mult (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  input  scol_pkg::front_t  up,
  input  logic              down_ready,
  output logic              ready,
  output logic              valid,
  output scol_pkg::mult_t   data
);
  import scol_pkg::*;

  mult_t data_next;

  assign ready = !valid || down_ready;

  always_comb begin
    logic signed [2*DIFF_W-1:0] prod;
    logic signed [CMP_W-1:0]    twod;
    logic signed [CMP_W-1:0]    lim;
    data_next.sphere = up.sphere;
    data_next.box_ok = 1'b1;
    data_next.rsq    = up.rs * up.rs;
    for (int ax = 0; ax < 3; ax++) begin
      prod = signed'(up.diff[ax]) * signed'(up.diff[ax]);
      data_next.sq[ax] = prod[SQ_W-1:0];
      // strict overlap on this axis: |2d| < span sum
      twod = CMP_W'(signed'(up.diff[ax])) <<< 1;
      lim  = signed'(CMP_W'(up.span_sum[ax]));
      if (!((twod < lim) && (-lim < twod))) begin
        data_next.box_ok = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      data <= data_next;
    end
  end

endmodule

FILE: hdl/scol_decide.sv
// Third and fourth stages: distance sum, then the registered hit decision.
module scol_decide (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  input  scol_pkg::mult_t  up,
  input  logic             out_stall,
  output logic             ready,
  output logic             out_valid,
  output logic             hit
);
  import scol_pkg::*;

  sum_t s3;
  logic s3_valid;
  logic s4_ready;

  assign s4_ready = !out_valid || !out_stall;
  assign ready    = !s3_valid || s4_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready) begin
        s3_valid <= up_valid;
      end
      if (s4_ready) begin
        out_valid <= s3_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      s3.sphere  <= up.sphere;
      s3.box_ok  <= up.box_ok;
      s3.rsq     <= up.rsq;
      s3.dist_sq <= DIST_W'(up.sq[0]) + DIST_W'(up.sq[1]) + DIST_W'(up.sq[2]);
    end
    if (s4_ready) begin
      hit <= s3.sphere ? (s3.dist_sq < s3.rsq) : s3.box_ok;
    end
  end

  // Hold the pending sum while the output stage is blocked.
  a_s3_hold: assert property (@(posedge clk) disable iff (rst)
    s3_valid && !s4_ready |=> s3_valid && $stable(s3))
    else $error("stage 3 request changed while blocked");

endmodule
